/* hw/rtl/cbpt_pkg.sv */
// Shared types, widths, register indexes and rounding helpers for the cubic
// Bezier point and tangent evaluator. No dependencies.
package cbpt_pkg;

    // Fraction bits of the curve parameter t; 1 << PARAM_FRAC_BITS stands for 1.0.
    localparam int PARAM_FRAC_BITS = 16;

    localparam int IN_W       = 17;                  // param_t port width
    localparam int COORD_W    = 32;                  // Q16.16 coordinates
    localparam int T_W        = PARAM_FRAC_BITS + 1; // t, 1-t and their blends
    localparam int W_W        = T_W + 2;             // Bernstein weights, up to 3x
    localparam int D3_W       = COORD_W + 3;         // 3 * (p[j+1] - p[j])
    localparam int PP_W       = W_W + 1 + COORD_W;   // weight times coordinate
    localparam int TP_W       = T_W + 1 + D3_W;      // blend times scaled difference
    localparam int ACC_W      = T_W + COORD_W + 8;   // sums with headroom
    localparam int CMP_W      = (IN_W > T_W) ? IN_W : T_W;
    localparam int NUM_REGS   = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int STAGES     = 6;

    typedef logic        [T_W-1:0]     t_tval;
    typedef logic        [W_W-1:0]     t_weight;
    typedef logic        [2*T_W-1:0]   t_prod;
    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [D3_W-1:0]    t_diff3;
    typedef logic signed [PP_W-1:0]    t_pprod;
    typedef logic signed [TP_W-1:0]    t_tprod;
    typedef logic signed [ACC_W-1:0]   t_acc;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_P0_X,
        REG_P0_Y,
        REG_P1_X,
        REG_P1_Y,
        REG_P2_X,
        REG_P2_Y,
        REG_P3_X,
        REG_P3_Y
    } t_cfg_idx;

    localparam t_tval T_ONE  = {1'b1, {PARAM_FRAC_BITS{1'b0}}};
    localparam t_prod P_HALF = {{(2*T_W-PARAM_FRAC_BITS){1'b0}}, 1'b1,
                                {(PARAM_FRAC_BITS-1){1'b0}}};
    localparam t_acc  ACC_HALF = t_acc'(1) <<< (PARAM_FRAC_BITS - 1);
    localparam t_acc  SAT_MAX  = t_acc'(64'sh0000_0000_7FFF_FFFF);
    localparam t_acc  SAT_MIN  = t_acc'(-64'sh0000_0000_8000_0000);

    // Rounds a product of two Q0.F values back to Q0.F, half up.
    function automatic t_tval f_rnd(input t_prod p);
        t_prod sum;
        sum = p + P_HALF;
        return sum[PARAM_FRAC_BITS +: T_W];
    endfunction

    // Drops the parameter fraction bits with round half up (floor of x/ONE + 1/2)
    // and clamps the result to the signed coordinate range.
    function automatic t_coord f_round_sat(input t_acc x);
        t_acc r;
        t_coord res;
        r = (x + ACC_HALF) >>> PARAM_FRAC_BITS;
        if (r > SAT_MAX) begin
            res = SAT_MAX[COORD_W-1:0];
        end else if (r < SAT_MIN) begin
            res = SAT_MIN[COORD_W-1:0];
        end else begin
            res = r[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

/* hw/rtl/cubic_bezier_point_tangent.sv */
// Top level of the cubic Bezier point and tangent evaluator: control point
// registers and the six-stage evaluation pipeline. Depends on cbpt_pkg.
//
// Usage: write the four control points (signed Q16.16) through the configuration
// channel, index 0..7 in the order p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y.
// Indexes 8..15 are accepted and ignored. The configuration channel is always
// ready. Each word on the input channel carries t in unsigned Q1.16; values above
// 1.0 are clamped to 1.0. Each input word yields exactly one output word holding
// the curve point and its derivative with respect to t, both saturated to Q16.16.
// Throughput is one word per clock while the receiver takes every word: each of
// the six stages holds one word, so the multiplier pipeline sets the rate. When
// the receiver stalls, words pack into empty stages behind the output register
// and the input channel keeps accepting until all six stages are full; nothing
// is dropped or repeated. Reset clears all control points to zero and empties
// the pipeline. Configuration must only be written while no word is in flight.
module cubic_bezier_point_tangent
    import cbpt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [IN_W-1:0]      i_param_t,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [COORD_W-1:0]   o_point_x,
    output logic [COORD_W-1:0]   o_point_y,
    output logic [COORD_W-1:0]   o_tangent_x,
    output logic [COORD_W-1:0]   o_tangent_y,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COORD_W-1:0]   i_cfg_data
);

    // Control points, stored as the x and y coordinate of each of the four points.
    t_coord r_px [4];
    t_coord r_py [4];
    // Scaled differences 3 * (p[j+1] - p[j]) used by the tangent.
    t_diff3 r_d3x [3];
    t_diff3 r_d3y [3];

    // Pipeline occupancy and per-stage advance signals.
    logic [STAGES:1] r_vld;
    logic [STAGES:1] n_vld;
    logic [STAGES:1] adv;

    // Stage 1: clamped t and 1 - t.
    t_tval   r1_a, r1_s;
    t_tval   n1_a;
    // Stage 2: second-order blends.
    t_tval   r2_a, r2_s, r2_ss, r2_ts, r2_tt;
    // Stage 3: Bernstein weights and tangent blends (ss, 2ts, tt).
    t_weight r3_w [4];
    t_tval   r3_tw [3];
    // Stage 4: products.
    t_pprod  r4_px [4];
    t_pprod  r4_py [4];
    t_tprod  r4_tx [3];
    t_tprod  r4_ty [3];
    // Stage 5: sums.
    t_acc    r5_px, r5_py, r5_tx, r5_ty;
    // Stage 6: output register.
    t_coord  r6_px, r6_py, r6_tx, r6_ty;

    t_prod   m2_ss, m2_ts, m2_tt;
    t_prod   m3_w0, m3_w1, m3_w2, m3_w3;
    t_tval   rn3_w1, rn3_w2;

    // Configuration registers. The channel never pushes back.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_px[i] <= '0;
                r_py[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_P0_X: r_px[0] <= i_cfg_data;
                REG_P0_Y: r_py[0] <= i_cfg_data;
                REG_P1_X: r_px[1] <= i_cfg_data;
                REG_P1_Y: r_py[1] <= i_cfg_data;
                REG_P2_X: r_px[2] <= i_cfg_data;
                REG_P2_Y: r_py[2] <= i_cfg_data;
                REG_P3_X: r_px[3] <= i_cfg_data;
                REG_P3_Y: r_py[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The differences follow the control points in the cycle after, which is well
    // before any new word reaches the product stage.
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_d3x[j] <= (t_diff3'(r_px[j+1]) - t_diff3'(r_px[j])) * t_diff3'(3);
            r_d3y[j] <= (t_diff3'(r_py[j+1]) - t_diff3'(r_py[j])) * t_diff3'(3);
        end
    end

    // A stage takes a new word when it is empty or its word moves on this cycle.
    always_comb begin
        adv[STAGES] = !r_vld[STAGES] || i_ready;
        for (int k = STAGES - 1; k >= 1; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (adv[1]) begin
            n_vld[1] = i_valid;
        end
        for (int k = 2; k <= STAGES; k++) begin
            if (adv[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready = adv[1];
    assign o_valid = r_vld[STAGES];

    // Stage 1: clamp t to 1.0.
    always_comb begin
        if (CMP_W'(i_param_t) > CMP_W'(T_ONE)) begin
            n1_a = T_ONE;
        end else begin
            n1_a = i_param_t[T_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r1_a <= n1_a;
            r1_s <= T_ONE - n1_a;
        end
    end

    // Stage 2: (1-t)^2, t(1-t), t^2.
    assign m2_ss = r1_s * r1_s;
    assign m2_ts = r1_a * r1_s;
    assign m2_tt = r1_a * r1_a;

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r2_a  <= r1_a;
            r2_s  <= r1_s;
            r2_ss <= f_rnd(m2_ss);
            r2_ts <= f_rnd(m2_ts);
            r2_tt <= f_rnd(m2_tt);
        end
    end

    // Stage 3: cubic weights with the binomials 1, 3, 3, 1.
    assign m3_w0  = r2_ss * r2_s;
    assign m3_w1  = r2_ts * r2_s;
    assign m3_w2  = r2_ts * r2_a;
    assign m3_w3  = r2_tt * r2_a;
    assign rn3_w1 = f_rnd(m3_w1);
    assign rn3_w2 = f_rnd(m3_w2);

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r3_w[0]  <= W_W'(f_rnd(m3_w0));
            r3_w[1]  <= W_W'(rn3_w1) + (W_W'(rn3_w1) << 1);
            r3_w[2]  <= W_W'(rn3_w2) + (W_W'(rn3_w2) << 1);
            r3_w[3]  <= W_W'(f_rnd(m3_w3));
            r3_tw[0] <= r2_ss;
            // t(1-t) never exceeds a quarter, so doubling it stays in range.
            r3_tw[1] <= {r2_ts[T_W-2:0], 1'b0};
            r3_tw[2] <= r2_tt;
        end
    end

    // Stage 4: all weight-by-coordinate and blend-by-difference products.
    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            for (int i = 0; i < 4; i++) begin
                r4_px[i] <= $signed({1'b0, r3_w[i]}) * r_px[i];
                r4_py[i] <= $signed({1'b0, r3_w[i]}) * r_py[i];
            end
            for (int j = 0; j < 3; j++) begin
                r4_tx[j] <= $signed({1'b0, r3_tw[j]}) * r_d3x[j];
                r4_ty[j] <= $signed({1'b0, r3_tw[j]}) * r_d3y[j];
            end
        end
    end

    // Stage 5: exact sums.
    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r5_px <= t_acc'(r4_px[0]) + t_acc'(r4_px[1]) + t_acc'(r4_px[2])
                   + t_acc'(r4_px[3]);
            r5_py <= t_acc'(r4_py[0]) + t_acc'(r4_py[1]) + t_acc'(r4_py[2])
                   + t_acc'(r4_py[3]);
            r5_tx <= t_acc'(r4_tx[0]) + t_acc'(r4_tx[1]) + t_acc'(r4_tx[2]);
            r5_ty <= t_acc'(r4_ty[0]) + t_acc'(r4_ty[1]) + t_acc'(r4_ty[2]);
        end
    end

    // Stage 6: round, saturate and hold for the receiver.
    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r6_px <= f_round_sat(r5_px);
            r6_py <= f_round_sat(r5_py);
            r6_tx <= f_round_sat(r5_tx);
            r6_ty <= f_round_sat(r5_ty);
        end
    end

    assign o_point_x   = r6_px;
    assign o_point_y   = r6_py;
    assign o_tangent_x = r6_tx;
    assign o_tangent_y = r6_ty;

endmodule

/* hw/rtl/cbpt_chk.sv */
// Port-level checker for the cubic Bezier evaluator, bound to the top level.
// Depends on cbpt_pkg and cubic_bezier_point_tangent.
module cbpt_chk
    import cbpt_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_ready,
    input logic [IN_W-1:0]      i_param_t,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [COORD_W-1:0]   o_point_x,
    input logic [COORD_W-1:0]   o_point_y,
    input logic [COORD_W-1:0]   o_tangent_x,
    input logic [COORD_W-1:0]   o_tangent_y,
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [COORD_W-1:0]   i_cfg_data
);

    localparam int CNT_W = $clog2(STAGES + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;

    // Words accepted but not yet delivered.
    always_comb begin
        n_cnt = r_cnt + CNT_W'(in_acc) - CNT_W'(out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(STAGES))
        else $error("more words in flight than pipeline stages");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_cnt != '0))
        else $error("output word presented with nothing in flight");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc ##1 i_ready ##1 i_ready ##1 i_ready ##1 i_ready ##1 i_ready
        |=> o_valid)
        else $error("word not delivered after six unstalled cycles");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_point_x)
            && $stable(o_point_y) && $stable(o_tangent_x) && $stable(o_tangent_y)))
        else $error("stalled output word changed or dropped");

endmodule

bind cubic_bezier_point_tangent cbpt_chk u_cbpt_chk (.*);
